// File: rtl/lus_pkg.sv
// ============================================================================
// lus_pkg: shared types, constants and fixed-point helpers
// Q16.16 word format, saturation helpers and the divider lane record.
// ============================================================================
package lus_pkg;

    localparam int WORD_BITS     = 32;
    localparam int FRAC_BITS     = 16;
    localparam int QUO_BITS      = WORD_BITS + FRAC_BITS;
    localparam int REM_BITS      = WORD_BITS + 1;
    localparam int DIV_STEPS     = 4;
    localparam int DIV_CELLS     = QUO_BITS / DIV_STEPS;
    localparam int CFG_BITS      = 4;
    localparam int APB_AW        = 3;
    localparam int APB_DW        = 32;
    localparam int DEF_MAX_ORDER = 8;
    localparam int DEF_MAX_RHS   = 8;

    localparam logic REQ_COEF        = 1'b0;
    localparam logic REQ_RHS         = 1'b1;
    localparam logic REG_MATRIX_SIZE = 1'b0;
    localparam logic REG_RHS_COLUMNS = 1'b1;

    localparam logic [CFG_BITS-1:0] RST_MATRIX_SIZE = CFG_BITS'(8);
    localparam logic [CFG_BITS-1:0] RST_RHS_COLUMNS = CFG_BITS'(1);

    typedef logic signed [WORD_BITS-1:0] t_word;
    typedef logic [WORD_BITS-1:0]        t_umag;
    typedef logic [QUO_BITS-1:0]         t_mag;

    localparam t_word WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam t_word WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam t_mag  NEG_LIM  = t_mag'(1) << (WORD_BITS - 1);
    localparam t_mag  POS_LIM  = NEG_LIM - t_mag'(1);

    typedef struct packed {
        t_word value;
        logic  clip;
    } t_sat;

    typedef struct packed {
        logic                valid;
        logic                neg;
        t_umag               dm;
        logic [REM_BITS-1:0] rem;
        t_mag                nq;
    } t_div_lane;

    function automatic t_umag mag_of(input t_word v);
        return v[WORD_BITS-1] ? (t_umag'(0) - t_umag'(v)) : t_umag'(v);
    endfunction

    // saturating a + b, or a - b when sub is set
    function automatic t_sat sat_sum(input t_word a, input t_word b, input logic sub);
        logic signed [WORD_BITS:0] s;
        t_sat                      res;
        s = sub ? ({a[WORD_BITS-1], a} - {b[WORD_BITS-1], b})
                : ({a[WORD_BITS-1], a} + {b[WORD_BITS-1], b});
        res.clip = (s[WORD_BITS] != s[WORD_BITS-1]);
        if (res.clip) begin
            res.value = s[WORD_BITS] ? WORD_MIN : WORD_MAX;
        end else begin
            res.value = s[WORD_BITS-1:0];
        end
        return res;
    endfunction

    // apply sign to a magnitude and clip to one word
    function automatic t_sat sat_mag(input logic neg, input t_mag mag);
        t_sat res;
        res.clip = 1'b0;
        if (neg) begin
            if (mag > NEG_LIM) begin
                res.clip  = 1'b1;
                res.value = WORD_MIN;
            end else begin
                res.value = $signed(t_umag'(0) - mag[WORD_BITS-1:0]);
            end
        end else begin
            if (mag > POS_LIM) begin
                res.clip  = 1'b1;
                res.value = WORD_MAX;
            end else begin
                res.value = $signed(mag[WORD_BITS-1:0]);
            end
        end
        return res;
    endfunction

endpackage

// File: rtl/lus_if.sv
// ============================================================================
// lus_in_if / lus_out_if: request and result channels
// Valid/ready channels carrying one matrix element or one solution element.
// ============================================================================
interface lus_in_if import lus_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  req_type;
    t_word element_value;

    modport source (output valid, output req_type, output element_value, input ready);
    modport sink   (input valid, input req_type, input element_value, output ready);
endinterface

interface lus_out_if import lus_pkg::*; ();
    logic  valid;
    logic  ready;
    t_word solution_value;
    logic  last_element;
    logic  singular_pivot;
    logic  saturated;

    modport source (output valid, output solution_value, output last_element,
                    output singular_pivot, output saturated, input ready);
    modport sink   (input valid, input solution_value, input last_element,
                    input singular_pivot, input saturated, output ready);
endinterface

// File: rtl/lus_div_cell.sv
// ============================================================================
// lus_div_cell: one cell of the restoring divider chain
// Retires DIV_STEPS quotient bits and hands the lane to the next cell.
// ============================================================================
module lus_div_cell import lus_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_div_lane i_lane,
    output t_div_lane o_lane
);

    t_div_lane           n_lane;
    t_div_lane           r_lane;
    logic [REM_BITS-1:0] w_trial;

    always_comb begin
        n_lane  = i_lane;
        w_trial = '0;
        for (int s = 0; s < DIV_STEPS; s++) begin
            // shift in next numerator bit, quotient bit enters at the bottom
            w_trial   = {n_lane.rem[REM_BITS-2:0], n_lane.nq[QUO_BITS-1]};
            n_lane.nq = {n_lane.nq[QUO_BITS-2:0], 1'b0};
            if (w_trial >= {1'b0, n_lane.dm}) begin
                n_lane.rem   = w_trial - {1'b0, n_lane.dm};
                n_lane.nq[0] = 1'b1;
            end else begin
                n_lane.rem = w_trial;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane.valid <= 1'b0;
        end else begin
            r_lane.valid <= n_lane.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lane.neg <= n_lane.neg;
        r_lane.dm  <= n_lane.dm;
        r_lane.rem <= n_lane.rem;
        r_lane.nq  <= n_lane.nq;
    end

    assign o_lane = r_lane;

endmodule

// File: rtl/lu_linear_solver.sv
// ============================================================================
// lu_linear_solver: A * X = B solver, Doolittle LU without pivoting, Q16.16
// Load: one element per cycle, n*n elements of A then n*c of B; no ready gaps.
// Solve: each computed entry steps BASE, BASEW, RD/MUL/SAT/ACC per product term,
//   DIFF, DWAIT where the entry needs a quotient (divider chain), then WR.
// Drain: EMRD then EMOUT per element of X, n*c results; next load starts after.
// Reset: synchronous active low; n = 8, c = 1, load and flags cleared.
// ============================================================================
module lu_linear_solver import lus_pkg::*; #(
    parameter int MAX_ORDER = DEF_MAX_ORDER,
    parameter int MAX_RHS   = DEF_MAX_RHS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lus_in_if.sink            i_req,
    lus_out_if.source         o_sol,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int NW  = $clog2(MAX_ORDER + 1);
    localparam int CW  = $clog2(MAX_RHS + 1);
    localparam int LCW = (NW > CW) ? NW : CW;
    localparam int AAW = $clog2(MAX_ORDER * MAX_ORDER);
    localparam int ABW = $clog2(MAX_ORDER * MAX_RHS);
    localparam int YW  = $clog2(MAX_ORDER);
    localparam int DEPTH_A = MAX_ORDER * MAX_ORDER;
    localparam int DEPTH_B = MAX_ORDER * MAX_RHS;
    localparam logic [AAW-1:0] ROW_A = AAW'(MAX_ORDER);
    localparam logic [ABW-1:0] ROW_B = ABW'(MAX_RHS);

    // Sequencer: LOAD takes requests; BASE..WR compute one entry of LU, y or x;
    // EMRD/EMOUT drain X row-major.
    typedef enum logic [11:0] {
        S_LOAD  = 12'b000000000001,
        S_BASE  = 12'b000000000010,
        S_BASEW = 12'b000000000100,
        S_RD    = 12'b000000001000,
        S_MUL   = 12'b000000010000,
        S_SAT   = 12'b000000100000,
        S_ACC   = 12'b000001000000,
        S_DIFF  = 12'b000010000000,
        S_DWAIT = 12'b000100000000,
        S_WR    = 12'b001000000000,
        S_EMRD  = 12'b010000000000,
        S_EMOUT = 12'b100000000000
    } t_state;

    // Phase of the solve: factor A, forward substitution, back substitution
    typedef enum logic [2:0] {
        M_FACT = 3'b001,
        M_FWD  = 3'b010,
        M_BWD  = 3'b100
    } t_mode;

    function automatic logic [AAW-1:0] addr_a(input logic [NW-1:0] row,
                                              input logic [NW-1:0] col);
        return AAW'(row) * ROW_A + AAW'(col);
    endfunction

    function automatic logic [ABW-1:0] addr_b(input logic [NW-1:0] row,
                                              input logic [CW-1:0] col);
        return ABW'(row) * ROW_B + ABW'(col);
    endfunction

    t_state r_state, n_state;
    t_mode  r_mode;

    logic [CFG_BITS-1:0] r_cfg_n, r_cfg_c;
    logic [NW-1:0]       w_n, w_nm1;
    logic [CW-1:0]       w_c, w_cm1;

    logic                r_ld_b;
    logic [NW-1:0]       r_ld_row;
    logic [LCW-1:0]      r_ld_col;

    logic [NW-1:0]       r_i, r_j, r_k, r_kend;
    logic [CW-1:0]       r_col;

    t_word               r_base, r_div, r_acc, r_term, r_res;
    logic [2*WORD_BITS-1:0] r_prod_mag;
    logic                r_prod_neg;
    logic                r_sing, r_sat;

    // Working storage: A is factored in place, X overwrites B in place
    t_word mem_a [DEPTH_A];
    t_word mem_b [DEPTH_B];
    t_word mem_y [MAX_ORDER];
    t_word r_a_rd0, r_a_rd1, r_b_rd, r_y_rd;

    logic [AAW-1:0] w_a_raddr0, w_a_raddr1, w_a_waddr;
    logic [ABW-1:0] w_b_raddr, w_b_waddr;
    logic [YW-1:0]  w_y_raddr;
    logic           w_a_we, w_b_we, w_y_we;
    t_word          w_a_wdata, w_b_wdata;

    logic w_cfg_wr, w_in_acc, w_a_take, w_b_take, w_ld_row_end, w_solve_go;
    logic w_last_i, w_last_col, w_need_div, w_out_acc;
    t_word w_q_sel;
    t_umag w_mag_p, w_mag_q;
    logic [2*WORD_BITS-1:0] w_prod;
    t_sat  w_term, w_accsum, w_diff, w_qsat;

    t_div_lane w_lane [DIV_CELLS+1];

    // ------------------------------------------------------------------------
    // Configuration port: two 4-bit registers, always ready
    // ------------------------------------------------------------------------
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_RHS_COLUMNS) ? APB_DW'(r_cfg_c) : APB_DW'(r_cfg_n);

    // Effective order and column count: zero acts as one, clamp to maximum
    always_comb begin
        if (r_cfg_n == '0) begin
            w_n = NW'(1);
        end else if (32'(r_cfg_n) > MAX_ORDER) begin
            w_n = NW'(MAX_ORDER);
        end else begin
            w_n = NW'(r_cfg_n);
        end
        if (r_cfg_c == '0) begin
            w_c = CW'(1);
        end else if (32'(r_cfg_c) > MAX_RHS) begin
            w_c = CW'(MAX_RHS);
        end else begin
            w_c = CW'(r_cfg_c);
        end
    end
    assign w_nm1 = w_n - NW'(1);
    assign w_cm1 = w_c - CW'(1);

    // ------------------------------------------------------------------------
    // Request intake: wrong-kind elements are accepted and dropped
    // ------------------------------------------------------------------------
    assign i_req.ready  = (r_state == S_LOAD);
    assign w_in_acc     = i_req.valid && i_req.ready && !w_cfg_wr;
    assign w_a_take     = w_in_acc && !r_ld_b && (i_req.req_type == REQ_COEF);
    assign w_b_take     = w_in_acc && r_ld_b && (i_req.req_type == REQ_RHS);
    assign w_ld_row_end = r_ld_b ? (r_ld_col == LCW'(w_cm1)) : (r_ld_col == LCW'(w_nm1));
    assign w_solve_go   = w_b_take && w_ld_row_end && (r_ld_row == w_nm1);

    // ------------------------------------------------------------------------
    // Entry datapath
    // ------------------------------------------------------------------------
    assign w_last_i   = (r_i == w_nm1);
    assign w_last_col = (r_col == w_cm1);
    assign w_need_div = ((r_mode == M_FACT) && (r_i > r_j)) || (r_mode == M_BWD);

    always_comb begin
        unique case (r_mode)
            M_FACT:  w_q_sel = r_a_rd1;
            M_FWD:   w_q_sel = r_y_rd;
            M_BWD:   w_q_sel = r_b_rd;
            default: w_q_sel = r_a_rd1;
        endcase
    end

    assign w_mag_p  = mag_of(r_a_rd0);
    assign w_mag_q  = mag_of(w_q_sel);
    assign w_prod   = {{WORD_BITS{1'b0}}, w_mag_p} * {{WORD_BITS{1'b0}}, w_mag_q};
    // drop the fraction bits of the product: truncation toward zero
    assign w_term   = sat_mag(r_prod_neg, r_prod_mag[2*WORD_BITS-1:FRAC_BITS]);
    assign w_accsum = sat_sum(r_acc, r_term, 1'b0);
    assign w_diff   = sat_sum(r_base, r_acc, 1'b1);
    assign w_qsat   = sat_mag(w_lane[DIV_CELLS].neg, w_lane[DIV_CELLS].nq);

    // Launch a quotient into the divider chain; a zero pivot never enters it
    always_comb begin
        w_lane[0].valid = (r_state == S_DIFF) && w_need_div && (r_div != '0);
        w_lane[0].neg   = w_diff.value[WORD_BITS-1] ^ r_div[WORD_BITS-1];
        w_lane[0].dm    = mag_of(r_div);
        w_lane[0].rem   = '0;
        w_lane[0].nq    = {mag_of(w_diff.value), {FRAC_BITS{1'b0}}};
    end

    for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
        lus_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_lane  (w_lane[g]),
            .o_lane  (w_lane[g+1])
        );
    end

    // ------------------------------------------------------------------------
    // Memory addressing
    // ------------------------------------------------------------------------
    // Term reads use k; base reads use (i, j), divisor reads the diagonal
    assign w_a_raddr0 = addr_a(r_i, (r_state == S_RD) ? r_k : r_j);
    assign w_a_raddr1 = (r_state == S_RD)   ? addr_a(r_k, r_j) :
                        (r_mode == M_FACT)  ? addr_a(r_j, r_j) : addr_a(r_i, r_i);
    assign w_b_raddr  = addr_b((r_state == S_RD) ? r_k : r_i, r_col);
    assign w_y_raddr  = (r_state == S_RD) ? YW'(r_k) : YW'(r_i);

    assign w_a_we    = w_a_take || ((r_state == S_WR) && (r_mode == M_FACT));
    assign w_a_waddr = (r_state == S_LOAD) ? addr_a(r_ld_row, NW'(r_ld_col)) : addr_a(r_i, r_j);
    assign w_a_wdata = (r_state == S_LOAD) ? i_req.element_value : r_res;
    assign w_b_we    = w_b_take || ((r_state == S_WR) && (r_mode == M_BWD));
    assign w_b_waddr = (r_state == S_LOAD) ? addr_b(r_ld_row, CW'(r_ld_col)) : addr_b(r_i, r_col);
    assign w_b_wdata = (r_state == S_LOAD) ? i_req.element_value : r_res;
    assign w_y_we    = (r_state == S_WR) && (r_mode == M_FWD);

    always_ff @(posedge i_clk) begin
        if (w_a_we) begin
            mem_a[w_a_waddr] <= w_a_wdata;
        end
        r_a_rd0 <= mem_a[w_a_raddr0];
        r_a_rd1 <= mem_a[w_a_raddr1];
    end

    always_ff @(posedge i_clk) begin
        if (w_b_we) begin
            mem_b[w_b_waddr] <= w_b_wdata;
        end
        r_b_rd <= mem_b[w_b_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_y_we) begin
            mem_y[YW'(r_i)] <= r_res;
        end
        r_y_rd <= mem_y[w_y_raddr];
    end

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    assign w_out_acc = o_sol.valid && o_sol.ready;

    always_comb begin
        unique case (r_state)
            S_LOAD:  n_state = w_solve_go ? S_BASE : S_LOAD;
            S_BASE:  n_state = S_BASEW;
            S_BASEW: n_state = (r_k < r_kend) ? S_RD : S_DIFF;
            S_RD:    n_state = S_MUL;
            S_MUL:   n_state = S_SAT;
            S_SAT:   n_state = S_ACC;
            S_ACC:   n_state = ((r_k + NW'(1)) < r_kend) ? S_RD : S_DIFF;
            S_DIFF:  n_state = w_lane[0].valid ? S_DWAIT : S_WR;
            S_DWAIT: n_state = w_lane[DIV_CELLS].valid ? S_WR : S_DWAIT;
            S_WR:    n_state = ((r_mode == M_BWD) && (r_i == '0) && w_last_col) ?
                               S_EMRD : S_BASE;
            S_EMRD:  n_state = S_EMOUT;
            S_EMOUT: n_state = !w_out_acc ? S_EMOUT :
                               (w_last_i && w_last_col) ? S_LOAD : S_EMRD;
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_mode   <= M_FACT;
            r_cfg_n  <= RST_MATRIX_SIZE;
            r_cfg_c  <= RST_RHS_COLUMNS;
            r_ld_b   <= 1'b0;
            r_ld_row <= '0;
            r_ld_col <= '0;
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_kend   <= '0;
            r_col    <= '0;
            r_sing   <= 1'b0;
            r_sat    <= 1'b0;
        end else begin
            r_state <= n_state;

            // config write drops any partial load
            if (w_cfg_wr) begin
                if (paddr[2] == REG_RHS_COLUMNS) begin
                    r_cfg_c <= pwdata[CFG_BITS-1:0];
                end else begin
                    r_cfg_n <= pwdata[CFG_BITS-1:0];
                end
                r_ld_b   <= 1'b0;
                r_ld_row <= '0;
                r_ld_col <= '0;
            end else if (w_a_take || w_b_take) begin
                if (w_ld_row_end) begin
                    r_ld_col <= '0;
                    if (r_ld_row == w_nm1) begin
                        r_ld_row <= '0;
                        r_ld_b   <= !r_ld_b;
                    end else begin
                        r_ld_row <= r_ld_row + NW'(1);
                    end
                end else begin
                    r_ld_col <= r_ld_col + LCW'(1);
                end
            end

            unique case (r_state)
                S_LOAD: begin
                    if (w_solve_go) begin
                        r_mode <= M_FACT;
                        r_i    <= '0;
                        r_j    <= '0;
                        r_col  <= '0;
                        r_sing <= 1'b0;
                        r_sat  <= 1'b0;
                    end
                end
                S_BASE: begin
                    unique case (r_mode)
                        M_FACT: begin
                            r_k    <= '0;
                            r_kend <= (r_i < r_j) ? r_i : r_j;
                        end
                        M_FWD: begin
                            r_k    <= '0;
                            r_kend <= r_i;
                        end
                        M_BWD: begin
                            r_k    <= r_i + NW'(1);
                            r_kend <= w_n;
                        end
                        default: begin
                            r_k    <= '0;
                            r_kend <= '0;
                        end
                    endcase
                end
                S_SAT: begin
                    if (w_term.clip) begin
                        r_sat <= 1'b1;
                    end
                end
                S_ACC: begin
                    r_k <= r_k + NW'(1);
                    if (w_accsum.clip) begin
                        r_sat <= 1'b1;
                    end
                end
                S_DIFF: begin
                    if (w_diff.clip) begin
                        r_sat <= 1'b1;
                    end
                    if (w_need_div && (r_div == '0)) begin
                        r_sing <= 1'b1;
                    end
                end
                S_DWAIT: begin
                    if (w_lane[DIV_CELLS].valid && w_qsat.clip) begin
                        r_sat <= 1'b1;
                    end
                end
                S_WR: begin
                    unique case (r_mode)
                        M_FACT: begin
                            if (w_last_i) begin
                                r_i <= '0;
                                if (r_j == w_nm1) begin
                                    r_mode <= M_FWD;
                                    r_col  <= '0;
                                end else begin
                                    r_j <= r_j + NW'(1);
                                end
                            end else begin
                                r_i <= r_i + NW'(1);
                            end
                        end
                        M_FWD: begin
                            if (w_last_i) begin
                                r_mode <= M_BWD;
                            end else begin
                                r_i <= r_i + NW'(1);
                            end
                        end
                        M_BWD: begin
                            if (r_i == '0) begin
                                if (w_last_col) begin
                                    r_col <= '0;
                                end else begin
                                    r_col  <= r_col + CW'(1);
                                    r_mode <= M_FWD;
                                end
                            end else begin
                                r_i <= r_i - NW'(1);
                            end
                        end
                        default: r_mode <= M_FACT;
                    endcase
                end
                S_EMOUT: begin
                    if (w_out_acc) begin
                        if (w_last_col) begin
                            r_col <= '0;
                            r_i   <= w_last_i ? '0 : (r_i + NW'(1));
                        end else begin
                            r_col <= r_col + CW'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Datapath payload registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_BASEW: begin
                unique case (r_mode)
                    M_FACT:  r_base <= r_a_rd0;
                    M_FWD:   r_base <= r_b_rd;
                    M_BWD:   r_base <= r_y_rd;
                    default: r_base <= r_a_rd0;
                endcase
                r_div <= r_a_rd1;
                r_acc <= '0;
            end
            S_MUL: begin
                r_prod_mag <= w_prod;
                r_prod_neg <= r_a_rd0[WORD_BITS-1] ^ w_q_sel[WORD_BITS-1];
            end
            S_SAT:   r_term <= w_term.value;
            S_ACC:   r_acc  <= w_accsum.value;
            S_DIFF:  r_res  <= w_need_div ? t_word'(0) : w_diff.value;
            S_DWAIT: begin
                if (w_lane[DIV_CELLS].valid) begin
                    r_res <= w_qsat.value;
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Result channel: hold the element until taken
    // ------------------------------------------------------------------------
    assign o_sol.valid          = (r_state == S_EMOUT);
    assign o_sol.solution_value = r_b_rd;
    assign o_sol.last_element   = w_last_i && w_last_col;
    assign o_sol.singular_pivot = r_sing;
    assign o_sol.saturated      = r_sat;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_cfg_clears_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_wr |=> (!r_ld_b && (r_ld_row == '0) && (r_ld_col == '0)))
        else $error("config write did not drop the partial load");

    a_div_only_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_lane[DIV_CELLS].valid |-> (r_state == S_DWAIT))
        else $error("divider result arrived with no entry waiting");

    a_term_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |-> (r_k < r_kend))
        else $error("accumulating a term past the end of the dot product");

    a_last_back_to_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_sol.last_element) |=> (r_state == S_LOAD))
        else $error("not back in load after the final element");

endmodule

// File: tb/lu_linear_solver_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lu_linear_solver_test: self-checking bench for the LU linear solver
// Loads A and B over the request channel, predicts X in Q16.16 with its own
// Doolittle solver, and checks every solution element and flag in order.
// ----------------------------------------------------------------------------
module lu_linear_solver_test import lus_pkg::*; ();

    typedef enum logic [2:0] {
        OP_ELEM, OP_WRITE, OP_SETTLE, OP_HOLDOFF, OP_CALM
    } t_op_kind;

    typedef struct {
        t_op_kind          kind;
        logic              rtype;
        t_word             val;
        logic [APB_AW-1:0] addr;
        logic [APB_DW-1:0] data;
    } t_plan_op;

    typedef struct {
        t_word value;
        logic  last;
        logic  sing;
        logic  sat;
    } t_sol_exp;

    localparam int QUIET_CYCLES = 64;
    localparam int HOLD_CYCLES  = 400;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata, prdata;
    logic pready;

    lus_in_if  req_if ();
    lus_out_if sol_if ();

    lu_linear_solver i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_sol   (sol_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Pending stimulus and expected solution elements
    t_plan_op plan_q[$];
    t_sol_exp sol_q[$];
    int       mismatches = 0;
    int       item_count = 0;

    // Shadow of the solver state
    logic [CFG_BITS-1:0] size_reg = RST_MATRIX_SIZE;
    logic [CFG_BITS-1:0] cols_reg = RST_RHS_COLUMNS;
    longint coef_mem[64];
    longint rhs_mem[64];
    int     fill_cnt = 0;
    bit     sing_flag, sat_flag;

    // Handshake bookkeeping shared between the edges
    bit req_took   = 0;
    int quiet      = 0;
    bit hold_start = 0;
    bit calm       = 0;

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
    end

    // ------------------------------------------------------------------
    // Q16.16 arithmetic: exact result, then clip to one word
    // ------------------------------------------------------------------
    function automatic longint clip_q(input longint v);
        if (v > 64'sd2147483647) begin
            sat_flag = 1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            sat_flag = 1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // product magnitude truncates toward zero
    function automatic longint q_mul(input longint a, input longint b);
        longint p;
        longint m;
        p = a * b;
        m = (p < 0) ? -p : p;
        m = m >>> FRAC_BITS;
        return clip_q((p < 0) ? -m : m);
    endfunction

    // a zero pivot yields zero and flags the solve as singular
    function automatic longint q_div(input longint a, input longint b);
        longint unsigned nm, dm, q;
        if (b == 0) begin
            sing_flag = 1;
            return 0;
        end
        nm = (a < 0) ? -a : a;
        dm = (b < 0) ? -b : b;
        q  = (nm << FRAC_BITS) / dm;
        return clip_q(((a < 0) != (b < 0)) ? -longint'(q) : longint'(q));
    endfunction

    function automatic int eff_dim(input logic [CFG_BITS-1:0] v);
        if (v == 0) return 1;
        return (v > 8) ? 8 : int'(v);
    endfunction

    // Factor A in place, solve every column, queue X in row-major order
    function automatic void solve_system(input int n, input int c);
        longint lu[64];
        longint y[8];
        longint x[64];
        longint acc;
        sing_flag = 0;
        sat_flag  = 0;
        for (int i = 0; i < n * n; i++) lu[i] = coef_mem[i];
        for (int j = 0; j < n; j++) begin
            for (int i = 0; i <= j; i++) begin
                acc = 0;
                for (int k = 0; k < i; k++)
                    acc = clip_q(acc + q_mul(lu[i*n+k], lu[k*n+j]));
                lu[i*n+j] = clip_q(lu[i*n+j] - acc);
            end
            for (int i = j + 1; i < n; i++) begin
                acc = 0;
                for (int k = 0; k < j; k++)
                    acc = clip_q(acc + q_mul(lu[i*n+k], lu[k*n+j]));
                lu[i*n+j] = q_div(clip_q(lu[i*n+j] - acc), lu[j*n+j]);
            end
        end
        for (int col = 0; col < c; col++) begin
            // unit lower diagonal: no division on the way down
            for (int i = 0; i < n; i++) begin
                acc = 0;
                for (int j = 0; j < i; j++)
                    acc = clip_q(acc + q_mul(lu[i*n+j], y[j]));
                y[i] = clip_q(rhs_mem[i*c+col] - acc);
            end
            for (int r = n - 1; r >= 0; r--) begin
                acc = 0;
                for (int j = r + 1; j < n; j++)
                    acc = clip_q(acc + q_mul(lu[r*n+j], x[j*c+col]));
                x[r*c+col] = q_div(clip_q(y[r] - acc), lu[r*n+r]);
            end
        end
        for (int i = 0; i < n * c; i++)
            sol_q.push_back('{t_word'(x[i]), (i == n * c - 1), sing_flag, sat_flag});
    endfunction

    // Track the load sequence; wrong element kinds are ignored
    function automatic void take_request(input logic rtype, input t_word val);
        int n, c, nn, total;
        n = eff_dim(size_reg);
        c = eff_dim(cols_reg);
        nn = n * n;
        total = nn + n * c;
        if (fill_cnt >= total) fill_cnt = 0;
        if (fill_cnt < nn) begin
            if (rtype == REQ_COEF) begin
                coef_mem[fill_cnt] = longint'(val);
                fill_cnt++;
            end
            return;
        end
        if (rtype != REQ_RHS) return;
        rhs_mem[fill_cnt - nn] = longint'(val);
        fill_cnt++;
        if (fill_cnt == total) begin
            fill_cnt = 0;
            solve_system(n, c);
        end
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        mismatches++;
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Monitor: sample both channels and the register port at the rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_sol_exp e;
        req_took = i_rst_n && req_if.valid && req_if.ready;
        if (i_rst_n && psel && penable && pwrite && pready) begin
            // any register write aborts a partial load
            if (paddr[2] == REG_MATRIX_SIZE) size_reg = pwdata[CFG_BITS-1:0];
            else cols_reg = pwdata[CFG_BITS-1:0];
            fill_cnt = 0;
        end
        if (req_took) take_request(req_if.req_type, req_if.element_value);
        if (i_rst_n && sol_if.valid && sol_if.ready) begin
            if (sol_q.size() == 0) begin
                report("unexpected result", sol_if.solution_value, 0);
            end else begin
                e = sol_q.pop_front();
                if (sol_if.solution_value !== e.value)
                    report("solution_value", sol_if.solution_value, e.value);
                if (sol_if.last_element !== e.last)
                    report("last_element", sol_if.last_element, e.last);
                if (sol_if.singular_pivot !== e.sing)
                    report("singular_pivot", sol_if.singular_pivot, e.sing);
                if (sol_if.saturated !== e.sat)
                    report("saturated", sol_if.saturated, e.sat);
            end
        end
        quiet = (sol_q.size() == 0) ? quiet + 1 : 0;
    end

    // ------------------------------------------------------------------
    // Driver: feed requests and register writes at the falling edge
    // ------------------------------------------------------------------
    initial begin
        req_if.valid         = 1'b0;
        req_if.req_type      = REQ_COEF;
        req_if.element_value = '0;
        sol_if.ready         = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
    end

    int apb_phase = 0;
    int idle_left = 0;

    always @(negedge i_clk) begin
        logic     nv;
        t_plan_op op;
        nv = req_if.valid && !req_took;
        if (!i_rst_n) begin
            nv = 1'b0;
        end else if (apb_phase == 1) begin
            penable <= 1'b1;
            apb_phase = 2;
        end else if (apb_phase == 2) begin
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            apb_phase = 0;
        end else if (!nv) begin
            if (idle_left > 0) begin
                idle_left--;
            end else if (plan_q.size() > 0) begin
                op = plan_q[0];
                case (op.kind)
                    OP_ELEM: begin
                        void'(plan_q.pop_front());
                        nv = 1'b1;
                        req_if.req_type      <= op.rtype;
                        req_if.element_value <= op.val;
                        if (!calm && $urandom_range(0, 5) == 0)
                            idle_left = $urandom_range(1, 15);
                    end
                    OP_WRITE: begin
                        // write only once the block has gone quiet
                        if (quiet > QUIET_CYCLES) begin
                            void'(plan_q.pop_front());
                            psel   <= 1'b1;
                            pwrite <= 1'b1;
                            paddr  <= op.addr;
                            pwdata <= op.data;
                            apb_phase = 1;
                        end
                    end
                    OP_SETTLE: begin
                        if (sol_q.size() == 0) void'(plan_q.pop_front());
                    end
                    OP_HOLDOFF: begin
                        void'(plan_q.pop_front());
                        hold_start = 1;
                    end
                    default: begin
                        void'(plan_q.pop_front());
                        calm = 1;
                    end
                endcase
            end
        end
        req_if.valid <= nv;
    end

    // Receiver: random stalls plus one long hold-off once results are offered
    int rx_gap  = 0;
    int rx_hold = 0;
    bit hold_done = 0;

    always @(negedge i_clk) begin
        if (hold_start && !hold_done && sol_if.valid) begin
            hold_done = 1;
            rx_hold = HOLD_CYCLES;
        end
        if (rx_hold > 0) begin
            rx_hold--;
            sol_if.ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            sol_if.ready <= 1'b0;
        end else begin
            sol_if.ready <= 1'b1;
            if (!calm && $urandom_range(0, 5) == 0) rx_gap = $urandom_range(1, 15);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus plan
    // ------------------------------------------------------------------
    task automatic put_op(input t_op_kind k);
        plan_q.push_back('{k, REQ_COEF, '0, '0, '0});
    endtask

    task automatic put_write(input logic reg_idx, input int value);
        plan_q.push_back('{OP_WRITE, REQ_COEF, '0, APB_AW'(4 * int'(reg_idx)), APB_DW'(value)});
    endtask

    // occasionally slip in an element of the wrong kind, which is ignored
    task automatic put_elem(input logic rtype, input t_word val, input bit noisy);
        if (noisy && $urandom_range(0, 11) == 0)
            plan_q.push_back('{OP_ELEM, ~rtype, t_word'($urandom), '0, '0});
        plan_q.push_back('{OP_ELEM, rtype, val, '0, '0});
        item_count++;
    endtask

    function automatic t_word pick_value(input int style, input bit diag);
        case (style)
            0: begin
                // well conditioned: dominant diagonal, modest entries
                if (diag) return t_word'(($urandom_range(0, 1) ? 1 : -1) *
                                         int'($urandom_range(8 << 16, 16 << 16)));
                return t_word'(int'($urandom_range(0, 1 << 17)) - (1 << 16));
            end
            1: return t_word'($urandom);
            2: return diag ? t_word'(0) : t_word'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
            default: begin
                case ($urandom_range(0, 3))
                    0: return WORD_MAX;
                    1: return WORD_MIN;
                    2: return t_word'(0);
                    default: return t_word'($urandom);
                endcase
            end
        endcase
    endfunction

    task automatic put_system(input int n, input int c, input int style);
        for (int i = 0; i < n * n; i++)
            put_elem(REQ_COEF, pick_value(style, (i / n) == (i % n)), 1);
        for (int i = 0; i < n * c; i++)
            put_elem(REQ_RHS, pick_value(style == 0 ? 2 : style, 0), 1);
    endtask

    task automatic put_config(input int nreg, input int creg);
        put_write(REG_MATRIX_SIZE, nreg);
        put_write(REG_RHS_COLUMNS, creg);
    endtask

    initial begin
        int nreg, creg, style;
        // Directed: scalar systems hitting the extremes
        put_config(1, 1);
        put_elem(REQ_RHS, 32'sd12345, 0);              // wrong kind, ignored
        put_elem(REQ_COEF, 32'sd0, 0);                 // zero pivot
        put_elem(REQ_COEF, 32'sd77, 0);                // wrong kind, ignored
        put_elem(REQ_RHS, 32'sd5 << 16, 0);
        put_elem(REQ_COEF, 32'sd1 << 16, 0);
        put_elem(REQ_RHS, WORD_MAX, 0);
        put_elem(REQ_COEF, WORD_MIN, 0);
        put_elem(REQ_RHS, WORD_MIN, 0);
        put_elem(REQ_COEF, 32'sd1, 0);                 // tiny pivot, quotient clips
        put_elem(REQ_RHS, WORD_MAX, 0);
        put_elem(REQ_COEF, -32'sd3 << 16, 0);
        put_elem(REQ_RHS, 32'sd7 << 16, 0);
        // zero and oversize registers fall back to 1 and the maximum
        put_config(0, 0);
        put_elem(REQ_COEF, WORD_MAX, 0);
        put_elem(REQ_RHS, WORD_MAX, 0);
        put_config(2, 1);
        put_system(2, 1, 0);
        put_system(2, 1, 2);
        put_config(15, 15);
        put_op(OP_HOLDOFF);
        put_system(8, 8, 0);
        // part of a further A, offered while the results are held back;
        // the next register write drops it
        for (int i = 0; i < 16; i++)
            put_elem(REQ_COEF, pick_value(0, 0), 0);
        put_op(OP_SETTLE);

        // Random phases, mostly small systems
        while (item_count < 430) begin
            if ($urandom_range(0, 9) == 0) begin
                nreg = $urandom_range(0, 15);
                creg = $urandom_range(0, 15);
            end else begin
                nreg = $urandom_range(1, 4);
                creg = $urandom_range(1, 3);
            end
            put_config(nreg, creg);
            repeat ($urandom_range(1, 3)) begin
                style = $urandom_range(0, 9);
                style = (style < 6) ? 0 : (style < 8) ? 1 : (style < 9) ? 2 : 3;
                put_system(eff_dim(nreg[3:0]), eff_dim(creg[3:0]), style);
            end
            if ($urandom_range(0, 7) == 0) put_op(OP_SETTLE);
        end
        // Last stretch with no idling on either side
        put_op(OP_CALM);
        put_config(3, 2);
        put_system(3, 2, 0);
        put_system(3, 2, 1);
    end

    // ------------------------------------------------------------------
    // End of run
    // ------------------------------------------------------------------
    initial begin
        @(posedge i_rst_n);
        repeat (4) @(posedge i_clk);
        wait (plan_q.size() == 0 && apb_phase == 0 && !req_if.valid && sol_q.size() == 0);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && sol_q.size() == 0) begin
            $display("PASS lu_linear_solver");
        end else begin
            $display("FAIL lu_linear_solver");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("timeout");
        $display("FAIL lu_linear_solver");
        $finish;
    end

endmodule
